FILE: rtl/core/rbb_pkg.sv
// Shared types and constants of the RGB 3x3 box blur.
package rbb_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 13;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [FW_W-1:0]  FW_RESET     = 11'd1024;
  localparam logic [FH_W-1:0]  FH_RESET     = 13'd768;
  localparam logic [FH_W-1:0]  HEIGHT_LIMIT = 13'd4096;
  localparam logic [ROW_W-1:0] ROW_MAX      = 13'd8191;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rbb_pix_t;

  typedef struct packed {
    logic first;
    logic emit;
    logic last;
    logic top_off;
    logic bot_off;
    logic left_off;
    logic right_off;
  } rbb_ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [CNT_W-1:0] count;
  } rbb_sum_t;

  typedef struct packed {
    rbb_pix_t pix;
    logic     last;
  } rbb_res_t;

endpackage

FILE: rtl/core/rbb_line_buf.sv
// Two line memories holding the rows above, with read-modify-write and forwarding.
module rbb_line_buf #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [COL_W-1:0] acc_col,
  input  rbb_pkg::rbb_pix_t acc_pix,
  input  rbb_pkg::rbb_ctl_t acc_ctl,
  output logic             p1_valid,
  output rbb_pkg::rbb_ctl_t p1_ctl,
  output rbb_pkg::rbb_pix_t p1_top,
  output rbb_pkg::rbb_pix_t p1_mid,
  output rbb_pkg::rbb_pix_t p1_pix
);
  import rbb_pkg::*;

  rbb_pix_t upper_mem [MAX_WIDTH];
  rbb_pix_t middle_mem [MAX_WIDTH];

  rbb_pix_t         up_rd_r;
  rbb_pix_t         mid_rd_r;
  rbb_pix_t         pix1_r;
  rbb_ctl_t         ctl1_r;
  logic [COL_W-1:0] col1_r;
  logic             v1_r;

  logic             fw_v_r;
  logic [COL_W-1:0] fw_col_r;
  rbb_pix_t         fw_up_r;
  rbb_pix_t         fw_mid_r;

  logic             hit;
  rbb_pix_t         top;
  rbb_pix_t         mid;

  // A write that lands on the same edge as the read of the same column is not
  // seen by the memory output, so the last write is kept and forwarded.
  assign hit = fw_v_r && (fw_col_r == col1_r);
  assign top = hit ? fw_up_r : up_rd_r;
  assign mid = hit ? fw_mid_r : mid_rd_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      up_rd_r  <= upper_mem[acc_col];
      mid_rd_r <= middle_mem[acc_col];
    end
    if (v1_r) begin
      upper_mem[col1_r]  <= mid;
      middle_mem[col1_r] <= pix1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      col1_r <= acc_col;
      pix1_r <= acc_pix;
      ctl1_r <= acc_ctl;
    end
    if (v1_r) begin
      fw_col_r <= col1_r;
      fw_up_r  <= mid;
      fw_mid_r <= pix1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      fw_v_r <= 1'b0;
    end else begin
      v1_r <= acc;
      if (v1_r) begin
        fw_v_r <= 1'b1;
      end
    end
  end

  assign p1_valid = v1_r;
  assign p1_ctl   = ctl1_r;
  assign p1_top   = top;
  assign p1_mid   = mid;
  assign p1_pix   = pix1_r;

endmodule

FILE: rtl/core/rbb_win_sum.sv
// 3x3 window registers and the masked per-channel neighborhood sums.
module rbb_win_sum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             p1_valid,
  input  rbb_pkg::rbb_ctl_t p1_ctl,
  input  rbb_pkg::rbb_pix_t p1_top,
  input  rbb_pkg::rbb_pix_t p1_mid,
  input  rbb_pkg::rbb_pix_t p1_pix,
  output logic             p2_busy,
  output logic             p3_valid,
  output rbb_pkg::rbb_sum_t p3_sum,
  output logic             p3_last
);
  import rbb_pkg::*;

  rbb_pix_t window_r [9];
  rbb_pix_t window_nxt [9];
  rbb_pix_t base [9];
  rbb_ctl_t p2_ctl_r;
  logic     p2_v_r;
  logic     p3_v_r;
  logic     p3_last_r;
  rbb_sum_t p3_sum_r;
  rbb_sum_t sum_nxt;
  logic [2:0] row_en;
  logic [2:0] col_en;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      base[i] = p1_ctl.first ? '0 : window_r[i];
    end
    for (int rr = 0; rr < 3; rr++) begin
      window_nxt[rr*3]     = base[rr*3 + 1];
      window_nxt[rr*3 + 1] = base[rr*3 + 2];
    end
    window_nxt[2] = p1_top;
    window_nxt[5] = p1_mid;
    window_nxt[8] = p1_pix;
  end

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      window_r <= window_nxt;
      p2_ctl_r <= p1_ctl;
    end
  end

  always_comb begin
    row_en = {~p2_ctl_r.bot_off, 1'b1, ~p2_ctl_r.top_off};
    col_en = {~p2_ctl_r.right_off, 1'b1, ~p2_ctl_r.left_off};
    sum_nxt = '0;
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        if (row_en[rr] && col_en[cc]) begin
          sum_nxt.red   = sum_nxt.red + SUM_W'(window_r[rr*3 + cc].red);
          sum_nxt.green = sum_nxt.green + SUM_W'(window_r[rr*3 + cc].green);
          sum_nxt.blue  = sum_nxt.blue + SUM_W'(window_r[rr*3 + cc].blue);
          sum_nxt.count = sum_nxt.count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p2_v_r) begin
      p3_sum_r  <= sum_nxt;
      p3_last_r <= p2_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p2_v_r <= p1_valid && p1_ctl.emit;
      p3_v_r <= p2_v_r;
    end
  end

  assign p2_busy  = p2_v_r;
  assign p3_valid = p3_v_r;
  assign p3_sum   = p3_sum_r;
  assign p3_last  = p3_last_r;

endmodule

FILE: rtl/core/rbb_mean.sv
// Rounded mean per channel by shifts and reciprocal multiplication.
module rbb_mean (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             p3_valid,
  input  rbb_pkg::rbb_sum_t p3_sum,
  input  logic             p3_last,
  output logic             res_valid,
  output rbb_pkg::rbb_res_t res
);
  import rbb_pkg::*;

  localparam int RCP_W   = 15;
  localparam int MUL_W   = SUM_W + RCP_W;
  localparam int RCP_SH  = 16;
  localparam logic [RCP_W-1:0] RECIP3 = 15'd21846;
  localparam logic [RCP_W-1:0] RECIP9 = 15'd7282;

  // The result is (2*sum + count) / (2*count); the odd factor 3 or 9 is
  // removed by a multiply with a rounded-up reciprocal, exact in this range.
  function automatic logic [7:0] mean8(input logic [SUM_W-1:0] s,
                                       input logic [CNT_W-1:0] c);
    logic [SUM_W:0]   n;
    logic [SUM_W-1:0] x;
    logic [MUL_W-1:0] prod;
    logic [SUM_W:0]   q;
    n    = {s, 1'b0} + (SUM_W+1)'(c);
    x    = SUM_W'(n >> 1);
    prod = '0;
    q    = '0;
    case (c)
      4'd2: q = n >> 2;
      4'd4: q = n >> 3;
      4'd3: begin
        prod = MUL_W'(x) * MUL_W'(RECIP3);
        q    = (SUM_W+1)'(prod >> RCP_SH);
      end
      4'd6: begin
        x    = SUM_W'(n >> 2);
        prod = MUL_W'(x) * MUL_W'(RECIP3);
        q    = (SUM_W+1)'(prod >> RCP_SH);
      end
      4'd9: begin
        prod = MUL_W'(x) * MUL_W'(RECIP9);
        q    = (SUM_W+1)'(prod >> RCP_SH);
      end
      default: q = n >> 1;
    endcase
    return q[7:0];
  endfunction

  logic     res_v_r;
  rbb_res_t res_r;

  always_ff @(posedge clk) begin
    if (p3_valid) begin
      res_r.pix.red   <= mean8(p3_sum.red, p3_sum.count);
      res_r.pix.green <= mean8(p3_sum.green, p3_sum.count);
      res_r.pix.blue  <= mean8(p3_sum.blue, p3_sum.count);
      res_r.last      <= p3_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= p3_valid;
    end
  end

  assign res_valid = res_v_r;
  assign res       = res_r;

endmodule

FILE: rtl/core/rgb_box_blur_3x3.sv
// Top level of the streaming RGB 3x3 box blur with frame position control.
// Takes one request per clock and gives one result per clock when the output
// side keeps up. A result passes the line buffer, window, sum and mean stages
// after the request completing its window, and the window of pixel k is
// complete with request k+width+1, so width+1 drains flush a frame. The two
// line memories set the rate: each is read once at acceptance and written
// back the next cycle, with the last write forwarded when the same column
// comes back at once (width of one). A width or height write starts a new
// frame; any register write holds input off the next cycle. The line memories
// are never cleared: entries not yet written only feed window rows above the
// frame, which are masked out. An eight-entry result queue absorbs output
// stalls; input is held off once queued and in-flight results would fill it.
module rgb_box_blur_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [7:0]                      in_pixel_red,
  input  logic [7:0]                      in_pixel_green,
  input  logic [7:0]                      in_pixel_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_blur_red,
  output logic [7:0]                      out_blur_green,
  output logic [7:0]                      out_blur_blue,
  output logic                            out_frame_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rbb_pkg::*;

  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WEFF_W     = $clog2(MAX_WIDTH + 1);
  localparam int TOT_W      = WEFF_W + FH_W;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 5);

  logic [FW_W-1:0]   fw_r;
  logic [FH_W-1:0]   fh_r;
  logic              cfg_busy_r;
  logic [TOT_W-1:0]  total_m1_r;
  logic [COL_W-1:0]  in_col_r;
  logic [ROW_W-1:0]  in_row_r;
  logic [TOT_W-1:0]  out_cnt_r;
  logic              first_r;

  logic [WEFF_W-1:0] w_eff;
  logic [FH_W-1:0]   h_eff;
  logic [COL_W-1:0]  col;
  logic [WEFF_W-1:0] col_p1;
  logic              col_nz;
  logic              wrap;
  logic              acc;
  logic              cfg_acc;
  rbb_ctl_t          ctl0;
  rbb_pix_t          pix0;

  logic              p1_valid;
  rbb_ctl_t          p1_ctl;
  rbb_pix_t          p1_top;
  rbb_pix_t          p1_mid;
  rbb_pix_t          p1_pix;
  logic              p2_busy;
  logic              p3_valid;
  rbb_sum_t          p3_sum;
  logic              p3_last;
  logic              res_valid;
  rbb_res_t          res;

  rbb_res_t          fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FCNT_W-1:0] fcnt_r;
  logic              pop;
  logic [OCC_W-1:0]  occ;
  rbb_res_t          head;

  always_comb begin
    if (fw_r == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(fw_r);
    end
    if (fh_r == '0) begin
      h_eff = FH_W'(1);
    end else if (fh_r > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = fh_r;
    end
  end

  assign col    = (WEFF_W'(in_col_r) >= w_eff) ? '0 : in_col_r;
  assign col_p1 = WEFF_W'(col) + WEFF_W'(1);
  assign col_nz = (col != '0);
  assign wrap   = (col_p1 >= w_eff);
  assign acc    = in_valid && in_ready;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign pix0   = in_action ? '0 : {in_pixel_red, in_pixel_green, in_pixel_blue};

  always_comb begin
    ctl0.first     = first_r;
    ctl0.emit      = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && col_nz);
    ctl0.last      = ctl0.emit && (out_cnt_r >= total_m1_r);
    ctl0.top_off   = col_nz ? (in_row_r == ROW_W'(1)) : (in_row_r == ROW_W'(2));
    ctl0.bot_off   = col_nz ? ((ROW_W+1)'(in_row_r) >= (ROW_W+1)'(h_eff))
                            : ((ROW_W+1)'(in_row_r) >= (ROW_W+1)'(h_eff) + (ROW_W+1)'(1));
    ctl0.left_off  = col_nz ? (col == COL_W'(1)) : (w_eff == WEFF_W'(1));
    ctl0.right_off = !col_nz;
  end

  always_ff @(posedge clk) begin
    total_m1_r <= TOT_W'(w_eff) * TOT_W'(h_eff) - TOT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= FW_RESET;
      fh_r       <= FH_RESET;
      cfg_busy_r <= 1'b1;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_cnt_r  <= '0;
      first_r    <= 1'b1;
    end else begin
      cfg_busy_r <= cfg_acc;
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH: begin
            fw_r      <= cfg_data[FW_W-1:0];
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_cnt_r <= '0;
            first_r   <= 1'b1;
          end
          REG_FRAME_HEIGHT: begin
            fh_r      <= cfg_data[FH_W-1:0];
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_cnt_r <= '0;
            first_r   <= 1'b1;
          end
          default: begin
          end
        endcase
      end else if (acc) begin
        if (ctl0.last) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_cnt_r <= '0;
          first_r   <= 1'b1;
        end else begin
          first_r <= 1'b0;
          if (wrap) begin
            in_col_r <= '0;
            if (in_row_r != ROW_MAX) begin
              in_row_r <= in_row_r + ROW_W'(1);
            end
          end else begin
            in_col_r <= COL_W'(col_p1);
          end
          if (ctl0.emit) begin
            out_cnt_r <= out_cnt_r + TOT_W'(1);
          end
        end
      end
    end
  end

  rbb_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .acc_col  (col),
    .acc_pix  (pix0),
    .acc_ctl  (ctl0),
    .p1_valid (p1_valid),
    .p1_ctl   (p1_ctl),
    .p1_top   (p1_top),
    .p1_mid   (p1_mid),
    .p1_pix   (p1_pix)
  );

  rbb_win_sum u_win_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .p1_valid (p1_valid),
    .p1_ctl   (p1_ctl),
    .p1_top   (p1_top),
    .p1_mid   (p1_mid),
    .p1_pix   (p1_pix),
    .p2_busy  (p2_busy),
    .p3_valid (p3_valid),
    .p3_sum   (p3_sum),
    .p3_last  (p3_last)
  );

  rbb_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .p3_valid  (p3_valid),
    .p3_sum    (p3_sum),
    .p3_last   (p3_last),
    .res_valid (res_valid),
    .res       (res)
  );

  assign pop  = out_valid && out_ready;
  assign head = fifo_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fcnt_r <= fcnt_r + FCNT_W'(res_valid) - FCNT_W'(pop);
    end
  end

  assign occ = OCC_W'(fcnt_r) + OCC_W'(p1_valid && p1_ctl.emit) + OCC_W'(p2_busy)
             + OCC_W'(p3_valid) + OCC_W'(res_valid);

  assign in_ready       = !cfg_busy_r && (occ < OCC_W'(FIFO_DEPTH));
  assign cfg_ready      = 1'b1;
  assign out_valid      = (fcnt_r != '0);
  assign out_blur_red   = head.pix.red;
  assign out_blur_green = head.pix.green;
  assign out_blur_blue  = head.pix.blue;
  assign out_frame_last = head.last;

endmodule

FILE: rtl/core/rbb_checker.sv
// Port-level assertions for the RGB 3x3 box blur and their binding.
module rbb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_blur_red,
  input logic [7:0] out_blur_green,
  input logic [7:0] out_blur_blue,
  input logic       out_frame_last
);

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken in the cycle after a register write");

  a_ready_fall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(cfg_valid && cfg_ready) || $past(out_valid && !out_ready))
    else $error("input held off without a register write or an output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({out_blur_red, out_blur_green, out_blur_blue, out_frame_last}))
    else $error("stalled result changed or dropped");

endmodule

bind rgb_box_blur_3x3 rbb_checker u_rbb_checker (.*);

FILE: dv/rgb_box_blur_3x3_tb.sv
// Self-checking testbench for the RGB 3x3 box blur, with random stalls on input and output.
module rgb_box_blur_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbb_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int MAX_W = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_REQUESTS = 480;
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = ACT_PIXEL;
  logic [7:0] in_pixel_red = '0;
  logic [7:0] in_pixel_green = '0;
  logic [7:0] in_pixel_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_blur_red;
  logic [7:0] out_blur_green;
  logic [7:0] out_blur_blue;
  logic out_frame_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [FW_W-1:0] cur_width;
  logic [FH_W-1:0] cur_height;
  rbb_pix_t line_above [MAX_W];
  rbb_pix_t line_prev [MAX_W];
  rbb_pix_t blur_window [9];
  int unsigned next_col;
  int unsigned next_row;
  int unsigned pixels_out;
  rbb_res_t pending_blur [$];

  int requests_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int stall_left = 0;
  bit no_gaps = 1'b0;

  rgb_box_blur_3x3 #(.MAX_WIDTH(MAX_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_pixel_red(in_pixel_red),
    .in_pixel_green(in_pixel_green),
    .in_pixel_blue(in_pixel_blue),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_blur_red(out_blur_red),
    .out_blur_green(out_blur_green),
    .out_blur_blue(out_blur_blue),
    .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int idle_len();
    int pick;
    if (no_gaps) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] random_channel();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic rbb_pix_t random_pixel();
    rbb_pix_t px;
    px.red = random_channel();
    px.green = random_channel();
    px.blue = random_channel();
    return px;
  endfunction

  function automatic int frame_items(int w, int h);
    return w * h + w + 1;
  endfunction

  function automatic void restart_position();
    next_col = 0;
    next_row = 0;
    pixels_out = 0;
    foreach (blur_window[i]) blur_window[i] = '0;
  endfunction

  // Advances the window by one request and queues the blurred pixel it completes, if any.
  function automatic void predict_blur(logic action, rbb_pix_t px);
    int unsigned w, h, c, ccol, cr, cnt, sum_r, sum_g, sum_b;
    rbb_pix_t top, mid, cur, v;
    rbb_res_t res;
    logic emit;
    w = (cur_width == 0) ? 1 : (cur_width > MAX_W) ? MAX_W : cur_width;
    h = (cur_height == 0) ? 1 : (cur_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cur_height;
    c = (next_col >= w) ? 0 : next_col;
    cur = (action == ACT_DRAIN) ? '0 : px;
    top = line_above[c];
    mid = line_prev[c];
    line_above[c] = mid;
    line_prev[c] = cur;
    for (int unsigned r = 0; r < 3; r++) begin
      blur_window[r * 3] = blur_window[r * 3 + 1];
      blur_window[r * 3 + 1] = blur_window[r * 3 + 2];
    end
    blur_window[2] = top;
    blur_window[5] = mid;
    blur_window[8] = cur;
    emit = (next_row >= 2) || (next_row == 1 && c >= 1);
    if (c > 0) begin
      ccol = c - 1;
      cr = next_row - 1;
    end else begin
      ccol = w - 1;
      cr = next_row - 2;
    end
    if (c + 1 >= w) begin
      next_col = 0;
      if (next_row < ROW_MAX) next_row++;
    end else begin
      next_col = c + 1;
    end
    if (!emit) return;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt = 0;
    for (int unsigned r = 0; r < 3; r++) begin
      if (r == 0 && cr == 0) continue;
      if (r == 2 && cr + 1 >= h) continue;
      for (int unsigned k = 0; k < 3; k++) begin
        if (k == 0 && ccol == 0) continue;
        if (k == 2 && ccol + 1 >= w) continue;
        v = blur_window[r * 3 + k];
        sum_r += v.red;
        sum_g += v.green;
        sum_b += v.blue;
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    res.pix.red = 8'((2 * sum_r + cnt) / (2 * cnt));
    res.pix.green = 8'((2 * sum_g + cnt) / (2 * cnt));
    res.pix.blue = 8'((2 * sum_b + cnt) / (2 * cnt));
    res.last = (pixels_out + 1 >= w * h);
    if (res.last) restart_position();
    else pixels_out++;
    pending_blur.push_back(res);
  endfunction

  task automatic send_request(logic action, rbb_pix_t px);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_pixel_red <= px.red;
    in_pixel_green <= px.green;
    in_pixel_blue <= px.blue;
    do @(posedge clk); while (!in_ready);
    predict_blur(action, px);
    requests_sent++;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_blur.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_request(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH: begin
        cur_width = value[FW_W-1:0];
        restart_position();
      end
      REG_FRAME_HEIGHT: begin
        cur_height = value[FH_W-1:0];
        restart_position();
      end
      default: ;
    endcase
  endtask

  task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    settle_block();
    cfg_request(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    settle_block();
    cfg_request(REG_FRAME_WIDTH, w);
    cfg_request(REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Sends part of a frame, w*h pixels then w+1 drains; noisy swaps some of either kind.
  task automatic stream_frame(int w, int h, int first, int count, bit noisy);
    for (int idx = first; idx < first + count; idx++) begin
      if (idx < w * h) begin
        if (noisy && $urandom_range(0, 9) == 0) send_request(ACT_DRAIN, random_pixel());
        else send_request(ACT_PIXEL, random_pixel());
      end else if (noisy && $urandom_range(0, 2) == 0) begin
        send_request(ACT_PIXEL, random_pixel());
      end else begin
        send_request(ACT_DRAIN, random_pixel());
      end
    end
  endtask

  task automatic test_reset_defaults();
    no_gaps = 1'b1;
    stream_frame(MAX_W, FH_RESET, 0, 20, 0);
    write_one(REG_FRAME_WIDTH, 13'd3);
    stream_frame(3, FH_RESET, 0, 30, 0);
    no_gaps = 1'b0;
  endtask

  task automatic test_directed_corners();
    set_frame_size(13'd1, 13'd1);
    send_request(ACT_PIXEL, {8'hFF, 8'h00, 8'h80});
    send_request(ACT_DRAIN, '0);
    send_request(ACT_DRAIN, '0);
    set_frame_size(13'd2, 13'd2);
    send_request(ACT_PIXEL, {8'd1, 8'd1, 8'hFF});
    send_request(ACT_PIXEL, {8'd1, 8'd0, 8'd0});
    send_request(ACT_PIXEL, {8'd0, 8'd0, 8'hFF});
    send_request(ACT_PIXEL, {8'd0, 8'd1, 8'd0});
    send_request(ACT_PIXEL, {3{8'hFF}});
    send_request(ACT_DRAIN, '0);
    send_request(ACT_DRAIN, '0);
    set_frame_size(13'd3, 13'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_request(ACT_DRAIN, {3{8'hFF}});
      else send_request(ACT_PIXEL, {8'(i[0] ? 0 : 255), 8'(i * 32), 8'(255 - i * 29)});
    end
    repeat (4) send_request(ACT_DRAIN, '0);
  endtask

  task automatic test_register_limits();
    set_frame_size(13'd0, 13'd0);
    stream_frame(1, 1, 0, frame_items(1, 1), 0);
    set_frame_size(13'h1001, 13'd2);
    stream_frame(1, 2, 0, frame_items(1, 2), 0);
    set_frame_size(13'd2, 13'h1FFF);
    stream_frame(2, HEIGHT_LIMIT, 0, 40, 1);
  endtask

  task automatic test_midframe_writes();
    set_frame_size(13'd4, 13'd3);
    stream_frame(4, 3, 0, 7, 1);
    write_one(REG_SPARE_2, 13'($urandom_range(0, 8191)));
    stream_frame(4, 3, 7, frame_items(4, 3) - 7, 1);
    write_one(REG_SPARE_3, 13'd0);
    stream_frame(4, 3, 0, 9, 0);
    write_one(REG_FRAME_WIDTH, 13'd5);
    stream_frame(5, 3, 0, frame_items(5, 3), 0);
  endtask

  task automatic test_random_frames();
    int w, h, total, start, frame_no;
    start = requests_sent;
    frame_no = 0;
    w = 1;
    h = 1;
    while (requests_sent - start < RANDOM_REQUESTS) begin
      if (frame_no == 0 || $urandom_range(0, 9) < 6) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        set_frame_size(13'(w), 13'(h));
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      total = frame_items(w, h);
      if ($urandom_range(0, 9) == 0) begin
        stream_frame(w, h, 0, $urandom_range(1, total - 1), 1);
        write_one(REG_FRAME_WIDTH, 13'(w));
      end else begin
        stream_frame(w, h, 0, total, $urandom_range(0, 9) < 3);
      end
      if (frame_no % 5 == 4) settle_block();
      frame_no++;
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    rbb_res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_blur.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result %0d/%0d/%0d last %0b with nothing pending",
                   out_blur_red, out_blur_green, out_blur_blue, out_frame_last);
      end else begin
        want = pending_blur.pop_front();
        if (out_blur_red !== want.pix.red || out_blur_green !== want.pix.green ||
            out_blur_blue !== want.pix.blue || out_frame_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Result %0d: expected %0d/%0d/%0d last %0b, got %0d/%0d/%0d last %0b",
                     results_checked, want.pix.red, want.pix.green, want.pix.blue, want.last,
                     out_blur_red, out_blur_green, out_blur_blue, out_frame_last);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = idle_len();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    cur_width = FW_RESET;
    cur_height = FH_RESET;
    foreach (line_above[i]) begin
      line_above[i] = '0;
      line_prev[i] = '0;
    end
    restart_position();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_corners();
    test_register_limits();
    test_midframe_writes();
    test_random_frames();
    in_valid <= 1'b0;
    while (pending_blur.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (pending_blur.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_blur.size());
    end
    $display("Sent %0d requests and checked %0d blurred pixels, %0d of them wrong.",
             requests_sent, results_checked, mismatches);
    $display("Covered reset sizes, corner windows, zero and truncated sizes, mid-frame writes.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
